/* rtl/phit_pkg.sv */
package phit_pkg;

   localparam int OPCODE_W = 3;
   localparam int REG_FIELD_W = 5;
   localparam int LABEL_FIELD_W = 8;
   localparam int CYCLE_W = 32;
   localparam int STALL_W = 2;

   // Offset from the fetch cycle to the writeback cycle in the five-stage pipe.
   localparam logic [CYCLE_W-1:0] FETCH_TO_WB = 32'd4;
   // Bubbles that a writer one slot old costs without forwarding.
   localparam int MAX_BUBBLES = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_BEQ   = 3'd2,
      OP_BNE   = 3'd3,
      OP_LW    = 3'd4,
      OP_SW    = 3'd5,
      OP_J     = 3'd6,
      OP_LABEL = 3'd7
   } opcode_type;

endpackage

/* rtl/pipeline_hazard_issue_timer_top.sv */
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   opcode, reg_first, reg_second, reg_third, label_id
// rsp       out        rsp_valid / rsp_stall   fetch_cycle, writeback_cycle, stall_cycles, skipped
//
// Each item passes from acceptance to result through the input register and then
// the result register. A new item is taken every cycle while rsp is not stalled.
// The window lookup, the fetch-cycle add and the state update are combinational
// between the input register and the result register.
// Reset is synchronous and clears the window valid bits and all control state.
// While rsp_stall holds a result, an item in the input register waits there and req_stall rises.
module pipeline_hazard_issue_timer_top #(
   parameter int WINDOW_DEPTH = 4,
   parameter int REG_COUNT = 32,
   parameter int LABEL_COUNT = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  phit_pkg::opcode_type                  req_opcode,
   input  logic [phit_pkg::REG_FIELD_W-1:0]      req_reg_first,
   input  logic [phit_pkg::REG_FIELD_W-1:0]      req_reg_second,
   input  logic [phit_pkg::REG_FIELD_W-1:0]      req_reg_third,
   input  logic [phit_pkg::LABEL_FIELD_W-1:0]    req_label_id,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [phit_pkg::CYCLE_W-1:0]          rsp_fetch_cycle,
   output logic [phit_pkg::CYCLE_W-1:0]          rsp_writeback_cycle,
   output logic [phit_pkg::STALL_W-1:0]          rsp_stall_cycles,
   output logic                                  rsp_skipped
);
   import phit_pkg::*;

   localparam int RW = $clog2(REG_COUNT);
   localparam int LW = $clog2(LABEL_COUNT);
   localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int REG_CODES = 1 << REG_FIELD_W;
   localparam int LABEL_CODES = 1 << LABEL_FIELD_W;

   // Constant tables that fold field codes into the register and label ranges.
   logic [RW-1:0] reg_fold [REG_CODES];
   logic [LW-1:0] label_fold [LABEL_CODES];

   for (genvar i = 0; i < REG_CODES; i++) begin : g_reg_fold
      assign reg_fold[i] = RW'(i % REG_COUNT);
   end
   for (genvar i = 0; i < LABEL_CODES; i++) begin : g_label_fold
      assign label_fold[i] = LW'(i % LABEL_COUNT);
   end

   // Input register
   logic                     s1_valid_ff;
   opcode_type               s1_op_ff;
   logic [REG_FIELD_W-1:0]   s1_r1_ff, s1_r2_ff, s1_r3_ff;
   logic [LABEL_FIELD_W-1:0] s1_label_ff;

   // Block state
   logic                     win_valid_ff [WINDOW_DEPTH];
   logic [RW-1:0]            win_reg_ff [WINDOW_DEPTH];
   logic [CYCLE_W-1:0]       next_fetch_ff;
   logic                     first_done_ff;
   logic                     skipping_ff;
   logic [LW-1:0]            pending_label_ff;

   // Result register
   logic                     rsp_valid_ff;
   logic [CYCLE_W-1:0]       rsp_fetch_ff, rsp_wb_ff;
   logic [STALL_W-1:0]       rsp_bubbles_ff;
   logic                     rsp_skipped_ff;

   logic                     advance;
   logic                     process;
   logic                     accept;

   logic [RW-1:0]            r1, r2, r3;
   logic [LW-1:0]            lbl;
   logic                     skip_path;
   logic                     is_first;
   logic                     check_en;
   logic                     use_third;
   logic                     is_writer;
   logic                     is_branch;
   logic                     match [WINDOW_DEPTH];
   logic                     hit;
   logic [IW-1:0]            hit_idx;
   logic [STALL_W-1:0]       bubbles;
   logic [CYCLE_W-1:0]       fetch;
   logic                     cleared_valid [WINDOW_DEPTH];

   logic                     win_valid_in [WINDOW_DEPTH];
   logic [RW-1:0]            win_reg_in [WINDOW_DEPTH];
   logic [CYCLE_W-1:0]       next_fetch_in;
   logic                     skipping_in;
   logic [LW-1:0]            pending_label_in;
   logic [CYCLE_W-1:0]       rsp_fetch_in, rsp_wb_in;
   logic [STALL_W-1:0]       rsp_bubbles_in;
   logic                     rsp_skipped_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign r1  = reg_fold[s1_r1_ff];
   assign r2  = reg_fold[s1_r2_ff];
   assign r3  = reg_fold[s1_r3_ff];
   assign lbl = label_fold[s1_label_ff];

   always_comb begin
      use_third = 1'b0;
      is_writer = 1'b0;
      is_branch = 1'b0;
      unique case (s1_op_ff) inside
         OP_ADD, OP_SUB: begin
            use_third = 1'b1;
            is_writer = 1'b1;
         end
         OP_LW: begin
            is_writer = 1'b1;
         end
         OP_BEQ, OP_BNE, OP_J: begin
            is_branch = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign skip_path = (s1_op_ff == OP_LABEL) || skipping_ff;
   assign is_first  = !first_done_ff;
   assign check_en  = !skip_path && !is_first && (s1_op_ff != OP_J);

   // The youngest matching writer wins; scanning from the oldest lets it overwrite.
   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      for (int k = WINDOW_DEPTH - 1; k >= 0; k--) begin
         match[k] = win_valid_ff[k] &&
                    (win_reg_ff[k] == r1 || win_reg_ff[k] == r2 ||
                     (use_third && win_reg_ff[k] == r3));
         if (match[k]) begin
            hit = 1'b1;
            hit_idx = IW'(k);
         end
      end
   end

   always_comb begin
      bubbles = '0;
      if (check_en && hit && (32'(hit_idx) < MAX_BUBBLES)) begin
         bubbles = STALL_W'(MAX_BUBBLES - 32'(hit_idx));
      end
   end

   assign fetch = is_first ? '0 : next_fetch_ff + CYCLE_W'(bubbles);

   always_comb begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
         cleared_valid[k] = win_valid_ff[k] && !(check_en && hit && hit_idx == IW'(k));
      end
      for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
         win_valid_in[k] = cleared_valid[k-1];
         win_reg_in[k]   = win_reg_ff[k-1];
      end
      win_valid_in[0] = !skip_path && is_writer;
      win_reg_in[0]   = r1;

      next_fetch_in    = next_fetch_ff;
      skipping_in      = skipping_ff;
      pending_label_in = pending_label_ff;
      rsp_fetch_in     = '0;
      rsp_wb_in        = '0;
      rsp_bubbles_in   = '0;
      rsp_skipped_in   = 1'b1;

      if (skip_path) begin
         if (s1_op_ff == OP_LABEL && skipping_ff && lbl == pending_label_ff) begin
            skipping_in = 1'b0;
         end
         if (is_first) begin
            next_fetch_in = CYCLE_W'(1);
         end
      end else begin
         if (is_branch) begin
            skipping_in      = 1'b1;
            pending_label_in = lbl;
         end
         next_fetch_in  = fetch + CYCLE_W'(1);
         rsp_fetch_in   = fetch;
         rsp_wb_in      = fetch + FETCH_TO_WB;
         rsp_bubbles_in = bubbles;
         rsp_skipped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         next_fetch_ff    <= '0;
         first_done_ff    <= 1'b0;
         skipping_ff      <= 1'b0;
         pending_label_ff <= '0;
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            win_valid_ff[k] <= 1'b0;
         end
      end else begin
         // An empty input register takes an item even while the result is held.
         if (accept || process) begin
            s1_valid_ff <= accept;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (process) begin
            next_fetch_ff    <= next_fetch_in;
            first_done_ff    <= 1'b1;
            skipping_ff      <= skipping_in;
            pending_label_ff <= pending_label_in;
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
               win_valid_ff[k] <= win_valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_opcode;
         s1_r1_ff    <= req_reg_first;
         s1_r2_ff    <= req_reg_second;
         s1_r3_ff    <= req_reg_third;
         s1_label_ff <= req_label_id;
      end
      if (process) begin
         rsp_fetch_ff   <= rsp_fetch_in;
         rsp_wb_ff      <= rsp_wb_in;
         rsp_bubbles_ff <= rsp_bubbles_in;
         rsp_skipped_ff <= rsp_skipped_in;
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            win_reg_ff[k] <= win_reg_in[k];
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fetch_cycle     = rsp_fetch_ff;
   assign rsp_writeback_cycle = rsp_wb_ff;
   assign rsp_stall_cycles    = rsp_bubbles_ff;
   assign rsp_skipped         = rsp_skipped_ff;

endmodule

/* rtl/phit_checker.sv */
module phit_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [phit_pkg::CYCLE_W-1:0]       rsp_fetch_cycle,
   input logic [phit_pkg::CYCLE_W-1:0]       rsp_writeback_cycle,
   input logic [phit_pkg::STALL_W-1:0]       rsp_stall_cycles,
   input logic                               rsp_skipped
);
   import phit_pkg::*;

   // Skipped items and labels carry no timing.
   a_skipped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped |->
         rsp_fetch_cycle == '0 && rsp_writeback_cycle == '0 && rsp_stall_cycles == '0)
      else $error("skipped item carries timing");

   a_wb_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_skipped |-> rsp_writeback_cycle == rsp_fetch_cycle + FETCH_TO_WB)
      else $error("writeback cycle is not fetch plus four");

   // Reset clears the result register, so nothing can come out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fetch_cycle) && $stable(rsp_skipped))
      else $error("stalled result changed");

   // With the result register empty the block never pushes back.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall || $past(req_valid))
      else $error("request stalled while pipe empty");

endmodule

bind pipeline_hazard_issue_timer_top phit_checker u_phit_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_fetch_cycle     (rsp_fetch_cycle),
   .rsp_writeback_cycle (rsp_writeback_cycle),
   .rsp_stall_cycles    (rsp_stall_cycles),
   .rsp_skipped         (rsp_skipped)
);
